FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check an expression at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// Check that a condition is followed by a consequence in the next cycle.
`define ASSERT_THEN(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst, expr)
`define ASSERT_THEN(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/dbtq_pkg.sv
package dbtq_pkg;

   localparam int unsigned BANK_DEPTH_DEF = 256;
   localparam int unsigned BYTE_W = 8;

   // Item function codes
   localparam logic FUNC_APPEND = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   // Result fields other than the transmitted byte
   typedef struct packed {
      logic              tx_valid;
      logic              done_valid;
      logic [BYTE_W-1:0] done_count;
      logic              dropped;
      logic              busy_res;
      logic [BYTE_W-1:0] fill_level;
   } res_info_type;

endpackage

FILE: rtl/core/double_buffered_transmit_queue.sv
// Ping-pong transmit queue: two banks in one synchronous byte memory.
// An append or a tick that sends no byte shows its beat in the cycle after acceptance;
// a tick that sends a byte shows it after the registered memory read, its flags parked in ST_READ.
// Throughput: one item per cycle unless rsp_stall holds; a byte-sending tick stalls in ST_READ.
// Reset (synchronous, active high) clears counters, bank select, sending flag and output valid;
// the bank memory is not cleared, and no entry is read before it has been written.
`include "assert_macros.svh"

module double_buffered_transmit_queue #(
   parameter int unsigned BANK_DEPTH = dbtq_pkg::BANK_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  logic [dbtq_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                           req_end_of_string,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_tx_valid,
   output logic [dbtq_pkg::BYTE_W-1:0]    rsp_tx_byte,
   output logic                           rsp_done_valid,
   output logic [dbtq_pkg::BYTE_W-1:0]    rsp_done_count,
   output logic                           rsp_dropped,
   output logic                           rsp_busy_res,
   output logic [dbtq_pkg::BYTE_W-1:0]    rsp_fill_level
);
   import dbtq_pkg::*;

   // One extra address bit selects the bank
   localparam int unsigned ADDR_W = $clog2(BANK_DEPTH) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_HOLD
   } state_type;

   state_type         state_ff;
   res_info_type      pend_ff;
   res_info_type      rsp_ff;
   logic [BYTE_W-1:0] rsp_tx_byte_ff;

   res_info_type      info;
   logic              req_accept;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [BYTE_W-1:0] wr_data, rd_data;

   // Take a beat when the output register is empty or being drained this cycle,
   // but never while a memory read is in flight.
   assign req_stall  = (state_ff == ST_READ) || ((state_ff == ST_HOLD) && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   dbtq_ctrl #(
      .BANK_DEPTH (BANK_DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .func          (req_func),
      .data_byte     (req_data_byte),
      .end_of_string (req_end_of_string),
      .info          (info),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr)
   );

   dbtq_bank_ram #(
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output sequencer: hold the result beat until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE, ST_HOLD: begin
               if (req_accept) begin
                  if (info.tx_valid) begin
                     // park the flags until the byte comes back from memory
                     state_ff <= ST_READ;
                     pend_ff  <= info;
                  end else begin
                     state_ff       <= ST_HOLD;
                     rsp_ff         <= info;
                     rsp_tx_byte_ff <= '0;
                  end
               end else if ((state_ff == ST_HOLD) && !rsp_stall) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_READ: begin
               // merge the read byte with the parked flags
               state_ff       <= ST_HOLD;
               rsp_ff         <= pend_ff;
               rsp_tx_byte_ff <= rd_data;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = (state_ff == ST_HOLD);
   assign rsp_tx_valid   = rsp_ff.tx_valid;
   assign rsp_tx_byte    = rsp_tx_byte_ff;
   assign rsp_done_valid = rsp_ff.done_valid;
   assign rsp_done_count = rsp_ff.done_count;
   assign rsp_dropped    = rsp_ff.dropped;
   assign rsp_busy_res   = rsp_ff.busy_res;
   assign rsp_fill_level = rsp_ff.fill_level;

   `ASSERT_THEN(a_read_parks, clock, reset, req_accept && info.tx_valid, state_ff == ST_READ && req_stall)
   `ASSERT_THEN(a_read_delivers, clock, reset, state_ff == ST_READ, rsp_valid && rsp_tx_valid)
   `ASSERT_HOLDS(a_tx_done_apart, clock, reset, !rsp_valid || !(rsp_tx_valid && rsp_done_valid))

endmodule

FILE: rtl/core/dbtq_bank_ram.sv
module dbtq_bank_ram #(
   parameter int unsigned ADDR_W = 9
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [dbtq_pkg::BYTE_W-1:0]    wr_data,
   input  logic                           rd_en,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [dbtq_pkg::BYTE_W-1:0]    rd_data
);
   import dbtq_pkg::*;

   localparam int unsigned DEPTH = 1 << ADDR_W;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/dbtq_ctrl.sv
`include "assert_macros.svh"

module dbtq_ctrl #(
   parameter int unsigned BANK_DEPTH = dbtq_pkg::BANK_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              func,
   input  logic [dbtq_pkg::BYTE_W-1:0]       data_byte,
   input  logic                              end_of_string,
   output dbtq_pkg::res_info_type            info,
   output logic                              wr_en,
   output logic [$clog2(BANK_DEPTH):0]       wr_addr,
   output logic [dbtq_pkg::BYTE_W-1:0]       wr_data,
   output logic                              rd_en,
   output logic [$clog2(BANK_DEPTH):0]       rd_addr
);
   import dbtq_pkg::*;

   localparam int unsigned CNT_W = $clog2(BANK_DEPTH);
   localparam logic [CNT_W-1:0] FULL_MARK = CNT_W'(BANK_DEPTH - 1);

   logic             sel_ff, sel_in;
   logic [CNT_W-1:0] fill_cnt_ff, fill_cnt_in;
   logic [CNT_W-1:0] send_idx_ff, send_idx_in;
   logic [CNT_W-1:0] send_len_ff, send_len_in;
   logic             sending_ff, sending_in;

   logic             swap;
   logic             tx_flag, done_flag, drop_flag;
   logic [CNT_W+BYTE_W-1:0] fill_ext, done_ext;

   always_comb begin
      sel_in      = sel_ff;
      fill_cnt_in = fill_cnt_ff;
      send_idx_in = send_idx_ff;
      send_len_in = send_len_ff;
      sending_in  = sending_ff;
      swap        = 1'b0;
      tx_flag     = 1'b0;
      done_flag   = 1'b0;
      drop_flag   = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      if (accept) begin
         if (func == FUNC_APPEND) begin
            if (data_byte != '0) begin
               if (fill_cnt_ff < FULL_MARK) begin
                  wr_en       = 1'b1;
                  fill_cnt_in = fill_cnt_ff + CNT_W'(1);
               end else begin
                  drop_flag = 1'b1;
               end
            end
            if (end_of_string && !sending_ff) begin
               swap = 1'b1;
            end
         end else if (sending_ff) begin
            if (send_len_ff == '0) begin
               sending_in = 1'b0;
            end else if (send_idx_ff < send_len_ff) begin
               rd_en       = 1'b1;
               tx_flag     = 1'b1;
               send_idx_in = send_idx_ff + CNT_W'(1);
            end else begin
               done_flag  = 1'b1;
               sending_in = 1'b0;
               if (fill_cnt_ff != '0) begin
                  swap = 1'b1;
               end
            end
         end
         if (swap) begin
            sel_in      = ~sel_ff;
            send_len_in = fill_cnt_in;
            fill_cnt_in = '0;
            send_idx_in = '0;
            sending_in  = 1'b1;
         end
      end
   end

   // Report counts as their low byte
   assign fill_ext = {{BYTE_W{1'b0}}, fill_cnt_in};
   assign done_ext = {{BYTE_W{1'b0}}, send_len_ff};

   always_comb begin
      info            = '0;
      info.tx_valid   = tx_flag;
      info.done_valid = done_flag;
      info.done_count = done_flag ? done_ext[BYTE_W-1:0] : '0;
      info.dropped    = drop_flag;
      info.busy_res   = sending_in;
      info.fill_level = fill_ext[BYTE_W-1:0];
   end

   assign wr_addr = {sel_ff, fill_cnt_ff};
   assign wr_data = data_byte;
   assign rd_addr = {~sel_ff, send_idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff      <= 1'b0;
         fill_cnt_ff <= '0;
         send_idx_ff <= '0;
         send_len_ff <= '0;
         sending_ff  <= 1'b0;
      end else begin
         sel_ff      <= sel_in;
         fill_cnt_ff <= fill_cnt_in;
         send_idx_ff <= send_idx_in;
         send_len_ff <= send_len_in;
         sending_ff  <= sending_in;
      end
   end

   `ASSERT_HOLDS(a_idx_within_len, clock, reset, send_idx_ff <= send_len_ff)
   `ASSERT_HOLDS(a_fill_bounded, clock, reset, fill_cnt_ff <= FULL_MARK)
   `ASSERT_THEN(a_swap_starts, clock, reset, swap, sending_ff && send_idx_ff == '0 && fill_cnt_ff == '0)

endmodule
